// ----- hw/rtl/shared_pool_multi_stack_core_defines.svh -----
// Assertion macros used by the checker file of the shared-pool stack core.
// Each macro expects the signals aclk and aresetn in the scope where it is used.
`ifndef SHARED_POOL_MULTI_STACK_CORE_DEFINES_SVH
`define SHARED_POOL_MULTI_STACK_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SPMS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stack core check failed in %m");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SPMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stack core check failed in %m");

`endif

// ----- hw/rtl/spms_pkg.sv -----
// Shared types and constants of the shared-pool stack core.
// Used by the datapath, the controller, the top level and the checker.
package spms_pkg;

    localparam int NUM_STACKS_DEF = 4;
    localparam int POOL_SIZE_DEF  = 16;

    localparam int DATA_W   = 32;
    localparam int SN_W     = 2;
    localparam int STATUS_W = 2;

    // Input beat layout, lowest bit first: mode, stack number, push value.
    localparam int S_MODE_BIT = 0;
    localparam int S_SN_LSB   = 1;
    localparam int S_VAL_LSB  = S_SN_LSB + SN_W;
    localparam int S_TDATA_W  = ((S_VAL_LSB + DATA_W + 7) / 8) * 8;

    // Output beat layout, lowest bit first: status, popped value.
    localparam int M_STATUS_LSB = 0;
    localparam int M_POP_LSB    = STATUS_W;
    localparam int M_USED_W     = STATUS_W + DATA_W;
    localparam int M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;        // latch the beat, read the stack top and the free-head link
        logic pop_read;     // read link and data of the top slot
        logic push_commit;  // write back a push and post its result
        logic pop_commit;   // write back a pop and post its result
        logic refuse;       // post a refusal, no state change
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pop;
        logic sn_ok;
        logic pool_full;
        logic top_null;
        logic out_free;
    } sts_t;

endpackage

// ----- hw/rtl/spms_dpath.sv -----
// Datapath of the shared-pool stack core: slot data, slot links, stack tops,
// free head and the result register. Depends on spms_pkg.
module spms_dpath #(
    parameter int NUM_STACKS = spms_pkg::NUM_STACKS_DEF,
    parameter int POOL_SIZE  = spms_pkg::POOL_SIZE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [spms_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [spms_pkg::M_TDATA_W-1:0]   m_tdata,
    input  spms_pkg::cmd_t                   cmd,
    output spms_pkg::sts_t                   sts
);

    localparam int PW = $clog2(POOL_SIZE);
    localparam int LW = $clog2(POOL_SIZE + 1);
    localparam int TW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [LW-1:0] LINK_NULL = LW'(POOL_SIZE);
    localparam int PAD_W = spms_pkg::M_TDATA_W - spms_pkg::M_USED_W;

    logic [spms_pkg::DATA_W-1:0] data_mem [POOL_SIZE];
    logic [LW-1:0]               link_mem [POOL_SIZE];
    logic [LW-1:0]               top_mem  [NUM_STACKS];

    logic [NUM_STACKS-1:0] top_valid_reg, top_valid_next;
    logic [LW-1:0]         free_head_reg, free_head_next;
    logic [LW-1:0]         hwm_reg, hwm_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic                          mode_reg;
    logic [spms_pkg::SN_W-1:0]     sn_reg;
    logic [spms_pkg::DATA_W-1:0]   value_reg;
    logic [LW-1:0]                 top_rd_reg;
    logic                          top_vld_reg;
    logic [LW-1:0]                 link_rd_reg;
    logic [LW-1:0]                 link_addr_reg;
    logic [spms_pkg::DATA_W-1:0]   data_rd_reg;
    logic [spms_pkg::STATUS_W-1:0] status_reg;
    logic [spms_pkg::DATA_W-1:0]   popped_reg;

    logic                        in_mode;
    logic [spms_pkg::SN_W-1:0]   in_sn;
    logic [spms_pkg::DATA_W-1:0] in_value;
    logic                        in_ok;
    logic                        sn_ok;
    logic [TW+spms_pkg::SN_W-1:0] in_sn_wide, reg_sn_wide;
    logic [TW-1:0]               in_idx, reg_idx;

    logic [LW-1:0] top_eff, link_raw, link_eff;
    logic          fh_ok;
    logic [PW-1:0] fh_idx, top_slot;

    logic          link_re;
    logic [PW-1:0] link_ra;
    logic          link_we;
    logic [PW-1:0] link_wa;
    logic [LW-1:0] link_wd;
    logic          top_we;
    logic [LW-1:0] top_wd;
    logic          out_fire;

    assign in_mode  = s_tdata[spms_pkg::S_MODE_BIT];
    assign in_sn    = s_tdata[spms_pkg::S_SN_LSB +: spms_pkg::SN_W];
    assign in_value = s_tdata[spms_pkg::S_VAL_LSB +: spms_pkg::DATA_W];

    assign in_ok = 32'(in_sn) < 32'(NUM_STACKS);
    assign sn_ok = 32'(sn_reg) < 32'(NUM_STACKS);

    assign in_sn_wide  = {{TW{1'b0}}, in_sn};
    assign reg_sn_wide = {{TW{1'b0}}, sn_reg};
    assign in_idx      = in_sn_wide[TW-1:0];
    assign reg_idx     = reg_sn_wide[TW-1:0];

    // Slots at or above the high-water mark were never allocated, so their
    // link is taken as the reset chain value (next slot, or null for the last).
    assign link_raw = (link_addr_reg >= hwm_reg) ? link_addr_reg + LW'(1) : link_rd_reg;
    assign link_eff = (link_raw < LINK_NULL) ? link_raw : LINK_NULL;
    assign top_eff  = (top_vld_reg && (top_rd_reg < LINK_NULL)) ? top_rd_reg : LINK_NULL;
    assign fh_ok    = free_head_reg < LINK_NULL;
    assign fh_idx   = free_head_reg[PW-1:0];
    assign top_slot = top_eff[PW-1:0];

    assign link_re = cmd.pop_read || (cmd.start && fh_ok);
    assign link_ra = cmd.pop_read ? top_slot : fh_idx;
    assign link_we = cmd.push_commit || cmd.pop_commit;
    assign link_wa = cmd.push_commit ? fh_idx : top_slot;
    assign link_wd = cmd.push_commit ? top_eff : free_head_reg;
    assign top_we  = cmd.push_commit || cmd.pop_commit;
    assign top_wd  = cmd.push_commit ? free_head_reg : link_eff;
    assign out_fire = cmd.push_commit || cmd.pop_commit || cmd.refuse;

    always_ff @(posedge aclk) begin
        if (link_re) begin
            link_rd_reg <= link_mem[link_ra];
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop_read) begin
            data_rd_reg <= data_mem[top_slot];
        end
        if (cmd.push_commit) begin
            data_mem[fh_idx] <= value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start && in_ok) begin
            top_rd_reg <= top_mem[in_idx];
        end
        if (top_we) begin
            top_mem[reg_idx] <= top_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mode_reg      <= in_mode;
            sn_reg        <= in_sn;
            value_reg     <= in_value;
            top_vld_reg   <= in_ok && top_valid_reg[in_idx];
            link_addr_reg <= free_head_reg;
        end else if (cmd.pop_read) begin
            link_addr_reg <= top_eff;
        end
        if (out_fire) begin
            if (cmd.refuse) begin
                status_reg <= mode_reg ? spms_pkg::ST_EMPTY : spms_pkg::ST_FULL;
            end else begin
                status_reg <= spms_pkg::ST_DONE;
            end
            popped_reg <= cmd.pop_commit ? data_rd_reg : '0;
        end
    end

    always_comb begin
        free_head_next = free_head_reg;
        hwm_next       = hwm_reg;
        top_valid_next = top_valid_reg;
        if (cmd.push_commit) begin
            free_head_next = link_eff;
            if (free_head_reg >= hwm_reg) begin
                hwm_next = free_head_reg + LW'(1);
            end
        end else if (cmd.pop_commit) begin
            free_head_next = top_eff;
        end
        if (top_we) begin
            top_valid_next[reg_idx] = 1'b1;
        end
        if (out_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            hwm_reg       <= '0;
            top_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            free_head_reg <= free_head_next;
            hwm_reg       <= hwm_next;
            top_valid_reg <= top_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, popped_reg, status_reg};

    assign sts.is_pop    = (mode_reg == spms_pkg::MODE_POP);
    assign sts.sn_ok     = sn_ok;
    assign sts.pool_full = !fh_ok;
    assign sts.top_null  = (top_eff == LINK_NULL);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

endmodule

// ----- hw/rtl/spms_ctrl.sv -----
// Controller of the shared-pool stack core: sequences each operation through
// its memory reads and write-back. Depends on spms_pkg.
module spms_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output spms_pkg::cmd_t cmd,
    input  spms_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_POP  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (sts.is_pop && sts.sn_ok && !sts.top_null) begin
                    cmd.pop_read = 1'b1;
                    state_next   = S_POP;
                end else if (sts.out_free) begin
                    if (!sts.is_pop && sts.sn_ok && !sts.pool_full) begin
                        cmd.push_commit = 1'b1;
                    end else begin
                        cmd.refuse = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_POP: begin
                if (sts.out_free) begin
                    cmd.pop_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/shared_pool_multi_stack_core.sv -----
// Top level of the shared-pool stack core: controller plus datapath.
// Depends on spms_pkg, spms_ctrl and spms_dpath.

// NUM_STACKS stacks share one pool of POOL_SIZE 32-bit slots. Each input beat
// is a push or a pop on one stack and yields exactly one result beat carrying
// a status (done, push refused because the pool is full or the stack number is
// out of range, or pop refused because the stack is empty or the stack number
// is out of range) and the popped value, which is zero unless a pop succeeded.
// The block works on one operation at a time. After its beat is accepted, a
// push or a refused operation posts its result to the output register from
// the read state; a successful pop goes on from there to the pop state,
// because the top slot must first be read from the stack-top memory before
// its link and data can be read. The input stays closed until the result is
// posted, and a new beat can be accepted as soon as the previous result is
// in the output register, even while that result is still waiting for the
// downstream side; the block only holds when a second result would overwrite
// one not yet taken. No clearing pass follows reset: the free list starts as
// a chain through all slots, and a high-water mark stands in for the links of
// slots that were never allocated, so the block can take a beat as soon as
// reset is released. Slot data is undefined until pushed, but a pop only ever
// returns data that a push stored.
module shared_pool_multi_stack_core #(
    parameter int NUM_STACKS = spms_pkg::NUM_STACKS_DEF,
    parameter int POOL_SIZE  = spms_pkg::POOL_SIZE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0 up: mode (1), stack_number (2), push_value (32), zero fill.
    input  logic [spms_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0 up: status (2), popped_value (32), zero fill.
    output logic [spms_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    spms_pkg::cmd_t cmd;
    spms_pkg::sts_t sts;

    spms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    spms_dpath #(
        .NUM_STACKS (NUM_STACKS),
        .POOL_SIZE  (POOL_SIZE)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ----- hw/rtl/spms_checker.sv -----
// Port-level checker of the shared-pool stack core and its bind statement.
// Depends on spms_pkg and shared_pool_multi_stack_core_defines.svh.
`include "shared_pool_multi_stack_core_defines.svh"

module spms_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [spms_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [spms_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic [spms_pkg::STATUS_W-1:0] status;
    logic [spms_pkg::DATA_W-1:0]   popped;

    assign status = m_axis_tdata[spms_pkg::M_STATUS_LSB +: spms_pkg::STATUS_W];
    assign popped = m_axis_tdata[spms_pkg::M_POP_LSB +: spms_pkg::DATA_W];

    // One operation at a time: the input closes right after a beat is taken.
    `SPMS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Status codes run from done up to stack empty; nothing above that is legal.
    `SPMS_ASSERT_SAME(a_status_legal, m_axis_tvalid, status <= spms_pkg::ST_EMPTY)

    // A refused operation never returns data.
    `SPMS_ASSERT_SAME(a_refuse_zero, m_axis_tvalid && (status != spms_pkg::ST_DONE), popped == '0)

    `SPMS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind shared_pool_multi_stack_core spms_checker u_spms_checker (.*);

// ----- test/shared_pool_multi_stack_core_tb.sv -----
// Self-checking testbench for shared_pool_multi_stack_core: push/pop beats against a model.
// Depends on spms_pkg and the core RTL; needs no files or arguments.

module shared_pool_multi_stack_core_tb;
    import spms_pkg::*;

    localparam int NSTK   = NUM_STACKS_DEF;
    localparam int POOL   = POOL_SIZE_DEF;
    localparam int LINK_W = $clog2(POOL + 1);
    // The null link is the first slot number that does not exist.
    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(POOL);

    // One result beat as the core should produce it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   popped;
    } pool_answer_t;

    // Mirror of the slot pool: slot contents, the link of each slot, the top of
    // each stack and the head of the free list. Every accepted input beat is
    // applied here at once and the answer it must give is queued in order.
    class stack_pool_checker;
        logic [DATA_W-1:0] slot_value[POOL];
        logic [LINK_W-1:0] slot_next[POOL];
        logic [LINK_W-1:0] top_of[NSTK];
        logic [LINK_W-1:0] free_slot;
        pool_answer_t      expected_answers[$];
        int                errors;

        function new();
            for (int i = 0; i < POOL; i++) begin
                slot_value[i] = '0;
                slot_next[i]  = LINK_W'(i + 1);
            end
            for (int s = 0; s < NSTK; s++) begin
                top_of[s] = NO_SLOT;
            end
            free_slot = '0;
            errors    = 0;
        endfunction

        function void note_request(logic [S_TDATA_W-1:0] beat);
            logic              mode;
            logic [SN_W-1:0]   sn;
            logic [DATA_W-1:0] val;
            logic [LINK_W-1:0] slot;
            pool_answer_t      answer;
            mode   = beat[S_MODE_BIT];
            sn     = beat[S_SN_LSB +: SN_W];
            val    = beat[S_VAL_LSB +: DATA_W];
            answer = '{status: ST_DONE, popped: '0};
            if (mode == MODE_PUSH) begin
                if (int'(sn) >= NSTK || free_slot >= NO_SLOT) begin
                    answer.status = ST_FULL;
                end else begin
                    slot             = free_slot;
                    slot_value[slot] = val;
                    free_slot        = slot_next[slot];
                    slot_next[slot]  = top_of[sn];
                    top_of[sn]       = slot;
                end
            end else begin
                if (int'(sn) >= NSTK || top_of[sn] >= NO_SLOT) begin
                    answer.status = ST_EMPTY;
                end else begin
                    slot            = top_of[sn];
                    top_of[sn]      = slot_next[slot];
                    slot_next[slot] = free_slot;
                    free_slot       = slot;
                    answer.popped   = slot_value[slot];
                end
            end
            expected_answers.push_back(answer);
        endfunction

        function void check_response(logic [M_TDATA_W-1:0] beat);
            pool_answer_t      want;
            logic [STATUS_W-1:0] got_status;
            logic [DATA_W-1:0] got_value;
            got_status = beat[M_STATUS_LSB +: STATUS_W];
            got_value  = beat[M_POP_LSB +: DATA_W];
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual status %0d value %h",
                         $time, got_status, got_value);
                errors++;
                return;
            end
            want = expected_answers.pop_front();
            if (got_status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got_status);
                errors++;
            end
            if (got_value !== want.popped) begin
                $display("%0t: popped value mismatch, expected %h, actual %h",
                         $time, want.popped, got_value);
                errors++;
            end
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    stack_pool_checker pool_model;
    int                results_seen;
    int                burst_left;
    bit                long_hold_done;

    shared_pool_multi_stack_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 time unit clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Every result beat taken by the receiver is checked against the oldest
    // expected answer. Outputs are only looked at on the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            pool_model.check_response(m_axis_tdata);
            results_seen++;
        end
    end

    // Offer one operation. The sender works in bursts: when a burst is used up,
    // it drops tvalid for a random gap, possibly none, and starts a new burst of random length.
    // Inputs only move on the falling edge; acceptance is judged on the rising one.
    task automatic offer_op(input logic mode, input logic [SN_W-1:0] sn,
                            input logic [DATA_W-1:0] val);
        int                   gap;
        logic [S_TDATA_W-1:0] beat;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            repeat (gap) begin
                @(negedge aclk);
                s_axis_tvalid = 1'b0;
                s_axis_tdata  = S_TDATA_W'({$urandom(), $urandom()});
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        beat                          = '0;
        beat[S_MODE_BIT]              = mode;
        beat[S_SN_LSB +: SN_W]        = sn;
        beat[S_VAL_LSB +: DATA_W]     = val;
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = beat;
        do @(posedge aclk); while (!s_axis_tready);
        pool_model.note_request(beat);
    endtask

    // Push values are mostly random, with the two's complement extremes, all ones
    // and all zeros mixed in now and then.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: ready follows a pattern that is picked anew for each random span
    // (always ready, coin toss, mostly ready, one cycle in four). Once enough
    // results have gone by, it holds ready low for a long stretch while the
    // sender keeps offering, so the core's output fills and it must stall its
    // input side.
    initial begin
        int style;
        int span;
        int phase;
        m_axis_tready  = 1'b0;
        long_hold_done = 1'b0;
        phase          = 0;
        @(posedge aresetn);
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 60);
            repeat (span) begin
                if (!long_hold_done && results_seen >= 200) begin
                    long_hold_done = 1'b1;
                    @(negedge aclk);
                    m_axis_tready = 1'b0;
                    repeat (299) @(negedge aclk);
                end
                @(negedge aclk);
                phase++;
                case (style)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = $urandom_range(0, 1);
                    2:       m_axis_tready = ($urandom_range(0, 9) != 0);
                    default: m_axis_tready = (phase % 4 == 0);
                endcase
            end
        end
    end

    // Watchdog: far beyond the slowest correct run of the whole stimulus.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int             push_pct;
        int             focus;
        logic           mode;
        logic [SN_W-1:0] sn;
        logic [DATA_W-1:0] fill_values[7];

        pool_model    = new();
        results_seen  = 0;
        burst_left    = 0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. Every stack starts empty, so each pop is refused.
        for (int s = 0; s < NSTK; s++) begin
            offer_op(MODE_POP, SN_W'(s), $urandom());
        end
        // Fill the whole pool, spread over all stacks, with the extremes and the
        // alternating bit patterns among the values.
        fill_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                        32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001};
        for (int i = 0; i < POOL; i++) begin
            offer_op(MODE_PUSH, SN_W'(i % NSTK),
                     (i < 7) ? fill_values[i] : $urandom());
        end
        // The pool is full now, so the next push is refused.
        offer_op(MODE_PUSH, SN_W'(NSTK - 1), 32'h1234_5678);
        // One pop from every stack returns its most recent push.
        for (int s = 0; s < NSTK; s++) begin
            offer_op(MODE_POP, SN_W'(s), $urandom());
        end

        // Random part in segments. Each segment leans toward pushes, pops or
        // neither, so the pool swings between full and empty, and about half of
        // the segments work mostly on a single stack to build deep chains.
        for (int seg = 0; seg < 25; seg++) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 15;
                1:       push_pct = 50;
                default: push_pct = 85;
            endcase
            focus = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, NSTK - 1);
            repeat (30) begin
                mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
                if (focus >= 0 && $urandom_range(0, 9) != 0) begin
                    sn = SN_W'(focus);
                end else begin
                    sn = SN_W'($urandom_range(0, NSTK - 1));
                end
                offer_op(mode, sn, pick_value());
            end
        end

        @(negedge aclk);
        s_axis_tvalid = 1'b0;

        // Drain: wait for every expected answer, then keep watching the output so a
        // stray extra beat would still be caught.
        while (pool_model.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (pool_model.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
